### design/lpr_pkg.sv
// Shared types, widths and codes of the longest-prefix route lookup block.
package lpr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int PORT_BITS   = 4;

    localparam int ADDR_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PORT_W  = 4;
    localparam int INDEX_W = 10;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]    prefix;
        logic [ADDR_W-1:0]    mask;
        logic [ADDR_W-1:0]    hop;
        logic [PORT_BITS-1:0] port;
    } t_route;

    // One table read in flight toward the match unit.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_scan_beat;

    // Best route found so far in the current scan.
    typedef struct packed {
        logic                 have;
        logic [ADDR_W-1:0]    hop;
        logic [PORT_BITS-1:0] port;
        logic [IDX_W-1:0]     idx;
    } t_match_result;

endpackage

### design/lpr_route_ram.sv
// Route table memory with one write port and one registered read port.
module lpr_route_ram (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [lpr_pkg::IDX_W-1:0] i_wr_addr,
    input  lpr_pkg::t_route          i_wr_data,
    input  logic                     i_rd_en,
    input  logic [lpr_pkg::IDX_W-1:0] i_rd_addr,
    output lpr_pkg::t_route          o_rd_data
);

    lpr_pkg::t_route r_mem [lpr_pkg::TABLE_DEPTH];
    lpr_pkg::t_route r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/lpr_match_unit.sv
// Shared prefix compare unit that keeps the best matching route of a scan.
module lpr_match_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  lpr_pkg::t_scan_beat        i_beat,
    input  lpr_pkg::t_route            i_route,
    input  logic [lpr_pkg::ADDR_W-1:0] i_key,
    output lpr_pkg::t_match_result     o_result
);

    lpr_pkg::t_match_result     r_best;
    lpr_pkg::t_match_result     n_best;
    logic [lpr_pkg::ADDR_W-1:0] r_best_mask;
    logic [lpr_pkg::ADDR_W-1:0] n_best_mask;
    logic                       hit;
    logic                       better;

    assign hit    = ((i_key & i_route.mask) == i_route.prefix);
    assign better = !r_best.have || (r_best_mask < i_route.mask);

    always_comb begin
        n_best      = r_best;
        n_best_mask = r_best_mask;
        if (i_start) begin
            n_best.have = 1'b0;
        end else if (i_beat.valid && hit && better) begin
            // Strictly larger mask only, so the earliest route wins a tie.
            n_best.have = 1'b1;
            n_best.hop  = i_route.hop;
            n_best.port = i_route.port;
            n_best.idx  = i_beat.idx;
            n_best_mask = i_route.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.have <= 1'b0;
        end else begin
            r_best.have <= n_best.have;
        end
        r_best.hop  <= n_best.hop;
        r_best.port <= n_best.port;
        r_best.idx  <= n_best.idx;
        r_best_mask <= n_best_mask;
    end

    assign o_result = r_best;

endmodule

### design/longest_prefix_route_lookup.sv
// Top level of the IPv4 longest-prefix route lookup over a linear table.
//
//  channel  valid    stall    payload
//  input    i_valid  o_stall  i_cmd, i_address, i_route_mask, i_hop_address, i_out_port
//  output   o_valid  i_stall  o_status, o_found_hop, o_found_port, o_found_index
//
// Clear, append and unused commands pass from the transfer through S_DONE to the result.
// A lookup passes through S_SCAN, S_DRAIN and S_DONE, or S_DONE alone when the table is empty;
// the single read port of the route memory feeds one route per cycle to the
// shared compare unit.
// Reset empties the table at once; the memory itself is not cleared.
// A new item is taken only after the previous result has entered the output
// register, which holds it while i_stall is high.
module longest_prefix_route_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lpr_pkg::CMD_W-1:0]     i_cmd,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_address,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_route_mask,
    input  logic [lpr_pkg::ADDR_W-1:0]    i_hop_address,
    input  logic [lpr_pkg::PORT_W-1:0]    i_out_port,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lpr_pkg::STAT_W-1:0]    o_status,
    output logic [lpr_pkg::ADDR_W-1:0]    o_found_hop,
    output logic [lpr_pkg::PORT_W-1:0]    o_found_port,
    output logic [lpr_pkg::INDEX_W-1:0]   o_found_index
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                         r_state, n_state;
    logic [lpr_pkg::CNT_W-1:0]      r_count, n_count;
    logic [lpr_pkg::CNT_W-1:0]      r_limit, n_limit;
    logic [lpr_pkg::CNT_W-1:0]      r_ptr, n_ptr;
    logic [lpr_pkg::ADDR_W-1:0]     r_key, n_key;
    logic                           r_is_lookup, n_is_lookup;
    logic [lpr_pkg::STAT_W-1:0]     r_status, n_status;
    lpr_pkg::t_scan_beat            r_beat, n_beat;
    logic                           r_o_valid, n_o_valid;
    logic [lpr_pkg::STAT_W-1:0]     r_o_status, n_o_status;
    logic [lpr_pkg::ADDR_W-1:0]     r_o_hop, n_o_hop;
    logic [lpr_pkg::PORT_W-1:0]     r_o_port, n_o_port;
    logic [lpr_pkg::INDEX_W-1:0]    r_o_index, n_o_index;

    logic                           in_xfer;
    logic                           full;
    logic                           wr_en;
    logic                           rd_en;
    logic                           start;
    logic                           out_free;
    lpr_pkg::t_route                wr_route;
    lpr_pkg::t_route                rd_route;
    lpr_pkg::t_match_result         best;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign full     = (r_count == lpr_pkg::CNT_W'(lpr_pkg::TABLE_DEPTH));
    assign wr_en    = in_xfer && (i_cmd == lpr_pkg::CMD_APPEND) && !full;
    assign start    = in_xfer && (i_cmd == lpr_pkg::CMD_LOOKUP);
    assign rd_en    = (r_state == S_SCAN);
    assign out_free = !r_o_valid || !i_stall;

    assign wr_route.prefix = i_address;
    assign wr_route.mask   = i_route_mask;
    assign wr_route.hop    = i_hop_address;
    assign wr_route.port   = lpr_pkg::PORT_BITS'(i_out_port);

    lpr_route_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[lpr_pkg::IDX_W-1:0]),
        .i_wr_data (wr_route),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr[lpr_pkg::IDX_W-1:0]),
        .o_rd_data (rd_route)
    );

    lpr_match_unit u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_beat   (r_beat),
        .i_route  (rd_route),
        .i_key    (r_key),
        .o_result (best)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_limit     = r_limit;
        n_ptr       = r_ptr;
        n_key       = r_key;
        n_is_lookup = r_is_lookup;
        n_status    = r_status;
        n_beat.valid = 1'b0;
        n_beat.idx   = r_ptr[lpr_pkg::IDX_W-1:0];
        n_o_valid   = r_o_valid && i_stall;
        n_o_status  = r_o_status;
        n_o_hop     = r_o_hop;
        n_o_port    = r_o_port;
        n_o_index   = r_o_index;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key       = i_address;
                    n_is_lookup = 1'b0;
                    n_status    = lpr_pkg::STAT_OK;
                    n_state     = S_DONE;
                    case (i_cmd)
                        lpr_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        lpr_pkg::CMD_APPEND: begin
                            if (full) begin
                                n_status = lpr_pkg::STAT_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        lpr_pkg::CMD_LOOKUP: begin
                            n_is_lookup = 1'b1;
                            n_limit     = r_count;
                            n_ptr       = '0;
                            // An empty table skips the scan and reports a miss.
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_beat.valid = 1'b1;
                n_ptr        = r_ptr + 1'b1;
                if (n_ptr == r_limit) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (r_is_lookup && best.have) begin
                        n_o_status = lpr_pkg::STAT_OK;
                        n_o_hop    = best.hop;
                        n_o_port   = lpr_pkg::PORT_W'(best.port);
                        n_o_index  = lpr_pkg::INDEX_W'(best.idx);
                    end else begin
                        n_o_status = r_is_lookup ? lpr_pkg::STAT_MISS : r_status;
                        n_o_hop    = '0;
                        n_o_port   = '0;
                        n_o_index  = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_beat.valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_beat.valid <= n_beat.valid;
            r_o_valid   <= n_o_valid;
        end
        r_limit     <= n_limit;
        r_ptr       <= n_ptr;
        r_key       <= n_key;
        r_is_lookup <= n_is_lookup;
        r_status    <= n_status;
        r_beat.idx  <= n_beat.idx;
        r_o_status  <= n_o_status;
        r_o_hop     <= n_o_hop;
        r_o_port    <= n_o_port;
        r_o_index   <= n_o_index;
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found_hop   = r_o_hop;
    assign o_found_port  = r_o_port;
    assign o_found_index = r_o_index;

endmodule
